// File: sv/source_tokenizer_unit_assert.svh
// Assertion macros for the source tokenizer unit.
`ifndef SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TOKENIZER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define STU_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define STU_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// File: sv/stu_pkg.sv
// Shared types, constants and character functions for the source tokenizer.
package stu_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 16;
  localparam int COLUMN_BITS = 12;
  localparam int LEN_BITS    = 16;
  localparam int KIND_BITS   = 7;
  localparam int ERR_BITS    = 3;
  localparam int WBUF_DEPTH  = 9;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic [KIND_BITS-1:0] K_IDENT  = 7'd30;
  localparam logic [KIND_BITS-1:0] K_DEC    = 7'd31;
  localparam logic [KIND_BITS-1:0] K_FLOAT  = 7'd35;
  localparam logic [KIND_BITS-1:0] K_DSTR   = 7'd36;
  localparam logic [KIND_BITS-1:0] K_SSTR   = 7'd37;
  localparam logic [KIND_BITS-1:0] K_OROR   = 7'd38;
  localparam logic [KIND_BITS-1:0] K_BAR    = 7'd39;
  localparam logic [KIND_BITS-1:0] K_ANDAND = 7'd40;
  localparam logic [KIND_BITS-1:0] K_AMP    = 7'd41;
  localparam logic [KIND_BITS-1:0] K_NE     = 7'd42;
  localparam logic [KIND_BITS-1:0] K_NOT    = 7'd43;
  localparam logic [KIND_BITS-1:0] K_LE     = 7'd44;
  localparam logic [KIND_BITS-1:0] K_LT     = 7'd45;
  localparam logic [KIND_BITS-1:0] K_GE     = 7'd46;
  localparam logic [KIND_BITS-1:0] K_GT     = 7'd47;
  localparam logic [KIND_BITS-1:0] K_EQEQ   = 7'd48;
  localparam logic [KIND_BITS-1:0] K_ASSIGN = 7'd49;
  localparam logic [KIND_BITS-1:0] K_PLUS   = 7'd50;
  localparam logic [KIND_BITS-1:0] K_ARROW  = 7'd51;
  localparam logic [KIND_BITS-1:0] K_MINUS  = 7'd52;
  localparam logic [KIND_BITS-1:0] K_STAR   = 7'd53;
  localparam logic [KIND_BITS-1:0] K_SLASH  = 7'd54;
  localparam logic [KIND_BITS-1:0] K_PCT    = 7'd55;
  localparam logic [KIND_BITS-1:0] K_COMMA  = 7'd56;
  localparam logic [KIND_BITS-1:0] K_DOT    = 7'd57;
  localparam logic [KIND_BITS-1:0] K_SEMI   = 7'd58;
  localparam logic [KIND_BITS-1:0] K_COLON  = 7'd59;
  localparam logic [KIND_BITS-1:0] K_LPAR   = 7'd60;
  localparam logic [KIND_BITS-1:0] K_RPAR   = 7'd61;
  localparam logic [KIND_BITS-1:0] K_LBRK   = 7'd62;
  localparam logic [KIND_BITS-1:0] K_RBRK   = 7'd63;
  localparam logic [KIND_BITS-1:0] K_LBRC   = 7'd64;
  localparam logic [KIND_BITS-1:0] K_RBRC   = 7'd65;
  localparam logic [KIND_BITS-1:0] K_EOF    = 7'd66;
  localparam logic [KIND_BITS-1:0] K_ERROR  = 7'd67;

  localparam logic [ERR_BITS-1:0] E_NONE    = 3'd0;
  localparam logic [ERR_BITS-1:0] E_ILLEGAL = 3'd1;
  localparam logic [ERR_BITS-1:0] E_BAD_EXP = 3'd2;
  localparam logic [ERR_BITS-1:0] E_TWO_EXP = 3'd3;
  localparam logic [ERR_BITS-1:0] E_SUFFIX  = 3'd4;
  localparam logic [ERR_BITS-1:0] E_UNTERM  = 3'd5;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [OFFSET_BITS-1:0] off;
    logic [LEN_BITS-1:0]    len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [ERR_BITS-1:0]    err;
    logic                   last;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_xdigit(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // One-byte punctuation: valid bit then kind.
  function automatic logic [KIND_BITS:0] single_kind(input logic [7:0] b);
    logic [KIND_BITS:0] r;
    r = '0;
    unique case (b)
      "+": r = {1'b1, K_PLUS};
      "*": r = {1'b1, K_STAR};
      "%": r = {1'b1, K_PCT};
      ",": r = {1'b1, K_COMMA};
      ".": r = {1'b1, K_DOT};
      ";": r = {1'b1, K_SEMI};
      ":": r = {1'b1, K_COLON};
      "(": r = {1'b1, K_LPAR};
      ")": r = {1'b1, K_RPAR};
      "[": r = {1'b1, K_LBRK};
      "]": r = {1'b1, K_RBRK};
      "{": r = {1'b1, K_LBRC};
      "}": r = {1'b1, K_RBRC};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Keyword text, right aligned and zero padded.
  function automatic logic [8*WBUF_DEPTH-1:0] kw_word(input logic [4:0] i);
    logic [8*WBUF_DEPTH-1:0] w;
    w = '0;
    unique case (i)
      5'd0:  w = "package";
      5'd1:  w = "struct";
      5'd2:  w = "this";
      5'd3:  w = "init";
      5'd4:  w = "inout";
      5'd5:  w = "public";
      5'd6:  w = "private";
      5'd7:  w = "protected";
      5'd8:  w = "let";
      5'd9:  w = "const";
      5'd10: w = "var";
      5'd11: w = "func";
      5'd12: w = "if";
      5'd13: w = "else";
      5'd14: w = "while";
      5'd15: w = "for";
      5'd16: w = "return";
      5'd17: w = "Int64";
      5'd18: w = "Int32";
      5'd19: w = "Int16";
      5'd20: w = "Int8";
      5'd21: w = "UInt64";
      5'd22: w = "UInt32";
      5'd23: w = "UInt16";
      5'd24: w = "UInt8";
      5'd25: w = "Float64";
      5'd26: w = "Float32";
      5'd27: w = "Float16";
      5'd28: w = "false";
      5'd29: w = "true";
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/stu_scan.sv
// Front part: per-byte scanner that classifies bytes and forms token records.
module stu_scan import stu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] b,
  output push_t      push
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OP    = 4'd1;
  localparam logic [3:0] S_LINE  = 4'd2;
  localparam logic [3:0] S_BLOCK = 4'd3;
  localparam logic [3:0] S_BSTAR = 4'd4;
  localparam logic [3:0] S_IDENT = 4'd5;
  localparam logic [3:0] S_STR   = 4'd6;
  localparam logic [3:0] S_ZERO  = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;
  localparam logic [3:0] S_HEX   = 4'd9;
  localparam logic [3:0] S_BIN   = 4'd10;
  localparam logic [3:0] S_EXP0  = 4'd11;
  localparam logic [3:0] S_EXP   = 4'd12;

  localparam logic [1:0] B_DEC = 2'd0;
  localparam logic [1:0] B_OCT = 2'd1;
  localparam logic [1:0] B_HEX = 2'd2;
  localparam logic [1:0] B_BIN = 2'd3;

  logic [3:0]                    st_r, st_nxt;
  logic [7:0]                    pend_r, pend_nxt;
  logic [OFFSET_BITS-1:0]        tstart_r, tstart_nxt, off_r, off_nxt;
  logic [LINE_BITS-1:0]          tline_r, tline_nxt, line_r, line_nxt;
  logic [COLUMN_BITS-1:0]        tcol_r, tcol_nxt, col_r, col_nxt;
  logic [LEN_BITS-1:0]           tlen_r, tlen_nxt;
  logic [WBUF_DEPTH-1:0][7:0]    wbuf_r, wbuf_nxt;
  logic [3:0]                    flags_r, flags_nxt;
  logic                          stopped_r, stopped_nxt;

  logic                          v1, v2, disp, dec_c, endn, fail_c, restart, active;
  logic [ERR_BITS-1:0]           fcode;
  logic [KIND_BITS-1:0]          nkind, kwk;
  logic [KIND_BITS:0]            sk;
  logic [7:0]                    second;
  logic [KIND_BITS-1:0]          two_k, one_k;
  logic [8*WBUF_DEPTH-1:0]       cand;
  rec_t                          rec1, rec2, r0, r1;

  function automatic rec_t mk(input logic [KIND_BITS-1:0] k, input logic [OFFSET_BITS-1:0] o,
                              input logic [LEN_BITS-1:0] l, input logic [LINE_BITS-1:0] ln,
                              input logic [COLUMN_BITS-1:0] c, input logic [ERR_BITS-1:0] e);
    rec_t r;
    r.kind = k; r.off = o; r.len = l; r.line = ln; r.col = c; r.err = e; r.last = 1'b0;
    return r;
  endfunction

  // Keyword match over the buffered identifier prefix.
  always_comb begin
    cand = '0;
    kwk  = K_IDENT;
    if (tlen_r <= LEN_BITS'(WBUF_DEPTH)) begin
      for (int j = 0; j < WBUF_DEPTH; j++) begin
        if (j < int'(tlen_r)) cand[8*(int'(tlen_r)-1-j) +: 8] = wbuf_r[j];
      end
      for (int i = 29; i >= 0; i--) begin
        if (cand == kw_word(5'(i))) kwk = KIND_BITS'(i);
      end
    end
  end

  always_comb begin
    st_nxt = st_r; pend_nxt = pend_r; flags_nxt = flags_r; tlen_nxt = tlen_r;
    tstart_nxt = tstart_r; tline_nxt = tline_r; tcol_nxt = tcol_r;
    wbuf_nxt = wbuf_r; stopped_nxt = stopped_r;
    v1 = 1'b0; v2 = 1'b0; disp = 1'b0; dec_c = 1'b0; endn = 1'b0; fail_c = 1'b0;
    fcode = E_NONE; restart = 1'b0; rec1 = '0; rec2 = '0;
    second = 8'd0; two_k = K_SLASH; one_k = K_SLASH;
    nkind = flags_r[1] ? K_FLOAT : K_DEC + KIND_BITS'(flags_r[3:2]);
    sk = single_kind(b);

    unique case (st_r)
      S_OP: begin
        unique case (pend_r)
          "|": begin second = "|"; two_k = K_OROR;   one_k = K_BAR;    end
          "&": begin second = "&"; two_k = K_ANDAND; one_k = K_AMP;    end
          "!": begin second = "="; two_k = K_NE;     one_k = K_NOT;    end
          "<": begin second = "="; two_k = K_LE;     one_k = K_LT;     end
          ">": begin second = "="; two_k = K_GE;     one_k = K_GT;     end
          "=": begin second = "="; two_k = K_EQEQ;   one_k = K_ASSIGN; end
          "-": begin second = ">"; two_k = K_ARROW;  one_k = K_MINUS;  end
          default: begin second = 8'd0; two_k = K_SLASH; one_k = K_SLASH; end
        endcase
        if (pend_r == "/" && b == "/") st_nxt = S_LINE;
        else if (pend_r == "/" && b == "*") st_nxt = S_BLOCK;
        else if (pend_r != "/" && b == second) begin
          v1 = 1'b1; rec1 = mk(two_k, tstart_r, LEN_BITS'(2), tline_r, tcol_r, E_NONE);
          st_nxt = S_IDLE;
        end else begin
          v1 = 1'b1; rec1 = mk(one_k, tstart_r, LEN_BITS'(1), tline_r, tcol_r, E_NONE);
          disp = 1'b1;
        end
      end
      S_LINE: begin
        if (b == 8'h0a) st_nxt = S_IDLE;
        else if (b == 8'd0) disp = 1'b1;
      end
      S_BLOCK: begin
        if (b == "*") st_nxt = S_BSTAR;
        else if (b == 8'd0) disp = 1'b1;
      end
      S_BSTAR: begin
        if (b == "/") st_nxt = S_IDLE;
        else if (b == 8'd0) disp = 1'b1;
        else if (b != "*") st_nxt = S_BLOCK;
      end
      S_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          if (tlen_r < LEN_BITS'(WBUF_DEPTH)) wbuf_nxt[tlen_r[3:0]] = b;
          tlen_nxt = len_inc(tlen_r);
        end else begin
          v1 = 1'b1; rec1 = mk(kwk, tstart_r, tlen_r, tline_r, tcol_r, E_NONE);
          disp = 1'b1;
        end
      end
      S_STR: begin
        if (b == pend_r) begin
          v1 = 1'b1;
          rec1 = mk((pend_r == "\"") ? K_DSTR : K_SSTR, tstart_r, len_inc(tlen_r),
                    tline_r, tcol_r, E_NONE);
          st_nxt = S_IDLE;
        end else if (b == 8'd0) begin
          fail_c = 1'b1; fcode = E_UNTERM;
        end else tlen_nxt = len_inc(tlen_r);
      end
      S_ZERO: begin
        if (b == "x" || b == "X") begin
          flags_nxt = {B_HEX, 2'b00}; st_nxt = S_HEX; tlen_nxt = len_inc(tlen_r);
        end else if (b == "b" || b == "B") begin
          flags_nxt = {B_BIN, 2'b00}; st_nxt = S_BIN; tlen_nxt = len_inc(tlen_r);
        end else if (b >= "0" && b <= "7") begin
          flags_nxt = {B_OCT, 2'b00}; st_nxt = S_DEC; tlen_nxt = len_inc(tlen_r);
        end else begin
          st_nxt = S_DEC; dec_c = 1'b1;
        end
      end
      S_DEC: dec_c = 1'b1;
      S_HEX: begin
        if (is_xdigit(b)) tlen_nxt = len_inc(tlen_r);
        else if (b == "." && !flags_r[0]) begin
          flags_nxt = flags_r | 4'b0001; tlen_nxt = len_inc(tlen_r);
        end else if (b == "p" || b == "P") begin
          flags_nxt = flags_r | 4'b0010; st_nxt = S_EXP0; tlen_nxt = len_inc(tlen_r);
        end else endn = 1'b1;
      end
      S_BIN: begin
        if (b == "0" || b == "1") tlen_nxt = len_inc(tlen_r);
        else endn = 1'b1;
      end
      S_EXP0: begin
        if (b == "+" || b == "-" || is_digit(b)) begin
          st_nxt = S_EXP; tlen_nxt = len_inc(tlen_r);
        end else begin
          fail_c = 1'b1; fcode = E_BAD_EXP;
        end
      end
      S_EXP: begin
        if (is_digit(b)) tlen_nxt = len_inc(tlen_r);
        else if ((flags_r[3:2] == B_HEX) ? (b == "p" || b == "P") : (b == "e" || b == "E"))
          begin fail_c = 1'b1; fcode = E_TWO_EXP; end
        else endn = 1'b1;
      end
      default: disp = 1'b1;
    endcase

    if (dec_c) begin
      if (is_digit(b)) tlen_nxt = len_inc(tlen_r);
      else if (b == "." && !flags_r[0]) begin
        flags_nxt = flags_r | 4'b0011; tlen_nxt = len_inc(tlen_r);
      end else if (b == "e" || b == "E") begin
        flags_nxt = flags_r | 4'b0010; st_nxt = S_EXP0; tlen_nxt = len_inc(tlen_r);
      end else endn = 1'b1;
    end

    if (endn) begin
      if (b == "f" || b == "F") begin
        if (flags_r[1]) begin
          v1 = 1'b1; rec1 = mk(nkind, tstart_r, len_inc(tlen_r), tline_r, tcol_r, E_NONE);
          st_nxt = S_IDLE;
        end else begin
          fail_c = 1'b1; fcode = E_SUFFIX;
        end
      end else begin
        v1 = 1'b1; rec1 = mk(nkind, tstart_r, tlen_r, tline_r, tcol_r, E_NONE);
        disp = 1'b1;
      end
    end

    if (fail_c) begin
      v1 = 1'b1; rec1 = mk(K_ERROR, tstart_r, len_inc(tlen_r), tline_r, tcol_r, fcode);
      stopped_nxt = 1'b1; st_nxt = S_IDLE;
    end

    // Start the next token with the current byte.
    if (disp) begin
      st_nxt = S_IDLE;
      if (b == 8'd0) begin
        v2 = 1'b1; rec2 = mk(K_EOF, off_r, '0, line_r, col_r, E_NONE);
        restart = 1'b1;
      end else if (!is_space(b)) begin
        tstart_nxt = off_r; tline_nxt = line_r; tcol_nxt = col_r; tlen_nxt = LEN_BITS'(1);
        if (sk[KIND_BITS]) begin
          v2 = 1'b1; rec2 = mk(sk[KIND_BITS-1:0], off_r, LEN_BITS'(1), line_r, col_r, E_NONE);
        end else if (b == "|" || b == "&" || b == "!" || b == "<" || b == ">" ||
                     b == "=" || b == "-" || b == "/") begin
          pend_nxt = b; st_nxt = S_OP;
        end else if (b == "\"" || b == "'") begin
          pend_nxt = b; st_nxt = S_STR;
        end else if (is_alpha(b) || b == "_") begin
          wbuf_nxt[0] = b; st_nxt = S_IDENT;
        end else if (b == "0") begin
          flags_nxt = '0; st_nxt = S_ZERO;
        end else if (is_digit(b)) begin
          flags_nxt = '0; st_nxt = S_DEC;
        end else begin
          v2 = 1'b1; rec2 = mk(K_ERROR, off_r, LEN_BITS'(1), line_r, col_r, E_ILLEGAL);
          stopped_nxt = 1'b1;
        end
      end
    end

    if (restart) begin
      off_nxt = '0; line_nxt = LINE_BITS'(1); col_nxt = COLUMN_BITS'(1);
    end else begin
      off_nxt = (&off_r) ? off_r : off_r + 1'b1;
      line_nxt = line_r;
      if (b == 8'h0a) begin
        line_nxt = (&line_r) ? line_r : line_r + 1'b1;
        col_nxt = COLUMN_BITS'(1);
      end else col_nxt = (&col_r) ? col_r : col_r + 1'b1;
    end

    // Pack results to the front and flag the final one.
    r0 = v1 ? rec1 : rec2;
    r1 = rec2;
    if (v1 && v2) r1.last = 1'b1;
    else r0.last = 1'b1;
    active = acc && !stopped_r;
    push.n = active ? 2'(v1) + 2'(v2) : 2'd0;
    push.rec0 = r0;
    push.rec1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pend_r <= '0; tstart_r <= '0; off_r <= '0;
      line_r <= LINE_BITS'(1); col_r <= COLUMN_BITS'(1);
      flags_r <= '0; stopped_r <= 1'b0; tlen_r <= '0;
      tline_r <= LINE_BITS'(1); tcol_r <= COLUMN_BITS'(1);
    end else if (active) begin
      st_r <= st_nxt; pend_r <= pend_nxt; tstart_r <= tstart_nxt; off_r <= off_nxt;
      line_r <= line_nxt; col_r <= col_nxt; flags_r <= flags_nxt;
      stopped_r <= stopped_nxt; tlen_r <= tlen_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (active) wbuf_r <= wbuf_nxt;
  end

endmodule

// File: sv/stu_queue.sv
// Back part: result queue taking up to two words a cycle, delivering one unless stalled.
module stu_queue import stu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_t       push,
  output logic        room,
  output logic [Q_AW:0] cnt,
  output logic        out_valid,
  input  logic        out_stall,
  output rec_t        out_rec
);

  rec_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = cnt_r != '0;
  assign out_rec   = mem[rp_r];
  assign room      = cnt_r <= (Q_AW+1)'(Q_DEPTH - 2);
  assign cnt       = cnt_r;

  always_comb begin
    wp_nxt  = wp_r + Q_AW'(push.n);
    rp_nxt  = rp_r + Q_AW'(pop);
    cnt_nxt = cnt_r + (Q_AW+1)'(push.n) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wp_r] <= push.rec0;
    if (push.n == 2'd2) mem[wp_r + 1'b1] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/source_tokenizer_unit.sv
// Top level of the source tokenizer: scanner front, result queue back.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_stall     in_char_in
//  out_     output     out_valid / out_stall   token record fields, out_last_result
//
// One byte is scanned per cycle while in_stall is low. A byte may give two token
// words; the queue drains one word per cycle while out_stall is low, so a run of
// such bytes is held back by in_stall. in_stall rises when the 4-word queue
// cannot take two more words. After an error no further words come until reset.
// Reset is synchronous; the queue comes out of reset empty.
`include "source_tokenizer_unit_assert.svh"
module source_tokenizer_unit import stu_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_BITS-1:0]   out_token_kind,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [LEN_BITS-1:0]    out_token_length,
  output logic [LINE_BITS-1:0]   out_begin_line,
  output logic [COLUMN_BITS-1:0] out_begin_column,
  output logic [ERR_BITS-1:0]    out_error_code,
  output logic                   out_last_result
);

  push_t          push;
  rec_t           orec;
  logic           room, acc;
  logic [Q_AW:0]  qcnt;

  assign in_stall = !room;
  assign acc      = in_valid && room;

  stu_scan u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .b    (in_char_in),
    .push (push)
  );

  stu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .cnt      (qcnt),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rec  (orec)
  );

  assign out_token_kind   = orec.kind;
  assign out_start_offset = orec.off;
  assign out_token_length = orec.len;
  assign out_begin_line   = orec.line;
  assign out_begin_column = orec.col;
  assign out_error_code   = orec.err;
  assign out_last_result  = orec.last;

  `STU_ASSERT_IMP(a_room_on_accept, acc, qcnt <= (Q_AW+1)'(Q_DEPTH - 2), "byte taken, no room")
  `STU_ASSERT_IMP(a_pair_last, push.n == 2'd2, !push.rec0.last && push.rec1.last, "bad last flag")
  `STU_ASSERT_IMP(a_no_push_idle, !acc, push.n == 2'd0, "word pushed without byte")
  `STU_ASSERT_NXT(a_cnt_bound, 1'b1, qcnt <= (Q_AW+1)'(Q_DEPTH), "queue overflow")

endmodule

// File: test/tb.sv
// Self-checking testbench for the source tokenizer unit.
module tb;
  import stu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_MARK = 256;

  typedef enum logic [3:0] {
    SC_IDLE, SC_OP, SC_LINE, SC_BLOCK, SC_BSTAR, SC_IDENT, SC_STR,
    SC_ZERO, SC_DEC, SC_HEX, SC_BIN, SC_EXP0, SC_EXP
  } scan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_in = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_BITS-1:0] out_token_kind;
  logic [OFFSET_BITS-1:0] out_start_offset;
  logic [LEN_BITS-1:0] out_token_length;
  logic [LINE_BITS-1:0] out_begin_line;
  logic [COLUMN_BITS-1:0] out_begin_column;
  logic [ERR_BITS-1:0] out_error_code;
  logic out_last_result;

  source_tokenizer_unit dut (.*);

  always #5 clk = ~clk;

  // scanner shadow state
  scan_t sc_state;
  logic [7:0] sc_pend;
  logic [OFFSET_BITS-1:0] sc_tstart, sc_off;
  logic [LINE_BITS-1:0] sc_line, sc_tline;
  logic [COLUMN_BITS-1:0] sc_col, sc_tcol;
  logic [LEN_BITS-1:0] sc_tlen;
  logic [7:0] sc_word [9];
  logic [3:0] sc_flags;
  logic sc_stopped, sc_restart;
  rec_t step_recs [2];
  int step_n;

  rec_t token_expect [$];
  int byte_src [$];
  int n_sent = 0, n_tokens = 0, n_errors = 0, n_twins = 0;
  bit hold_used = 0;
  string kw_text [30] = '{"package", "struct", "this", "init", "inout", "public",
    "private", "protected", "let", "const", "var", "func", "if", "else", "while",
    "for", "return", "Int64", "Int32", "Int16", "Int8", "UInt64", "UInt32",
    "UInt16", "UInt8", "Float64", "Float32", "Float16", "false", "true"};

  function automatic bit c_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic bit c_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction
  function automatic bit c_xdigit(logic [7:0] b);
    return c_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction
  function automatic logic [LEN_BITS-1:0] sat_inc(logic [LEN_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void emit(logic [KIND_BITS-1:0] k, logic [OFFSET_BITS-1:0] o,
                               logic [LEN_BITS-1:0] l, logic [LINE_BITS-1:0] ln,
                               logic [COLUMN_BITS-1:0] c, logic [ERR_BITS-1:0] e);
    if (step_n < 2) begin
      step_recs[step_n] = '{kind: k, off: o, len: l, line: ln, col: c, err: e, last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void emit_tok(logic [KIND_BITS-1:0] k, logic [LEN_BITS-1:0] l);
    emit(k, sc_tstart, l, sc_tline, sc_tcol, E_NONE);
  endfunction

  function automatic void stop_on(logic [ERR_BITS-1:0] code);
    emit(K_ERROR, sc_tstart, sat_inc(sc_tlen), sc_tline, sc_tcol, code);
    sc_stopped = 1;
    sc_state = SC_IDLE;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind();
    bit hit;
    if (sc_tlen > 9) return K_IDENT;
    for (int i = 0; i < 30; i++) begin
      hit = kw_text[i].len() == sc_tlen;
      for (int j = 0; j < kw_text[i].len() && hit; j++)
        if (kw_text[i][j] != sc_word[j]) hit = 0;
      if (hit) return KIND_BITS'(i);
    end
    return K_IDENT;
  endfunction

  function automatic void start_token(logic [7:0] b);
    sc_state = SC_IDLE;
    if (b == 8'd0) begin
      emit(K_EOF, sc_off, '0, sc_line, sc_col, E_NONE);
      sc_restart = 1;
      return;
    end
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
    sc_tstart = sc_off;
    sc_tline = sc_line;
    sc_tcol = sc_col;
    sc_tlen = 1;
    case (b)
      "+": emit_tok(K_PLUS, 1);
      "*": emit_tok(K_STAR, 1);
      "%": emit_tok(K_PCT, 1);
      ",": emit_tok(K_COMMA, 1);
      ".": emit_tok(K_DOT, 1);
      ";": emit_tok(K_SEMI, 1);
      ":": emit_tok(K_COLON, 1);
      "(": emit_tok(K_LPAR, 1);
      ")": emit_tok(K_RPAR, 1);
      "[": emit_tok(K_LBRK, 1);
      "]": emit_tok(K_RBRK, 1);
      "{": emit_tok(K_LBRC, 1);
      "}": emit_tok(K_RBRC, 1);
      "|", "&", "!", "<", ">", "=", "-", "/": begin
        sc_pend = b;
        sc_state = SC_OP;
      end
      "\"", "'": begin
        sc_pend = b;
        sc_state = SC_STR;
      end
      default: begin
        if (c_alpha(b) || b == "_") begin
          sc_word[0] = b;
          sc_state = SC_IDENT;
        end else if (c_digit(b)) begin
          sc_flags = 0;
          sc_state = (b == "0") ? SC_ZERO : SC_DEC;
        end else begin
          sc_tlen = 0;
          stop_on(E_ILLEGAL);
        end
      end
    endcase
  endfunction

  function automatic void close_number(logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    k = sc_flags[1] ? K_FLOAT : K_DEC + KIND_BITS'(sc_flags[3:2]);
    if (b == "f" || b == "F") begin
      if (sc_flags[1]) begin
        emit_tok(k, sat_inc(sc_tlen));
        sc_state = SC_IDLE;
      end else stop_on(E_SUFFIX);
      return;
    end
    emit_tok(k, sc_tlen);
    start_token(b);
  endfunction

  function automatic void decimal_byte(logic [7:0] b);
    if (c_digit(b)) sc_tlen = sat_inc(sc_tlen);
    else if (b == "." && !sc_flags[0]) begin
      sc_flags[1:0] = 2'b11;
      sc_tlen = sat_inc(sc_tlen);
    end else if (b == "e" || b == "E") begin
      sc_flags[1] = 1;
      sc_state = SC_EXP0;
      sc_tlen = sat_inc(sc_tlen);
    end else close_number(b);
  endfunction

  function automatic void operator_byte(logic [7:0] b);
    logic [8:0] second;
    logic [KIND_BITS-1:0] two, one;
    case (sc_pend)
      "|": begin second = "|"; two = K_OROR; one = K_BAR; end
      "&": begin second = "&"; two = K_ANDAND; one = K_AMP; end
      "!": begin second = "="; two = K_NE; one = K_NOT; end
      "<": begin second = "="; two = K_LE; one = K_LT; end
      ">": begin second = "="; two = K_GE; one = K_GT; end
      "=": begin second = "="; two = K_EQEQ; one = K_ASSIGN; end
      "-": begin second = ">"; two = K_ARROW; one = K_MINUS; end
      default: begin
        if (b == "/") begin sc_state = SC_LINE; return; end
        if (b == "*") begin sc_state = SC_BLOCK; return; end
        second = 9'd256; two = K_SLASH; one = K_SLASH;
      end
    endcase
    if ({1'b0, b} == second) begin
      emit_tok(two, 2);
      sc_state = SC_IDLE;
      return;
    end
    emit_tok(one, 1);
    start_token(b);
  endfunction

  // Work out the token words one accepted byte produces and queue them.
  function automatic void predict_tokens(logic [7:0] b);
    step_n = 0;
    if (sc_stopped) return;
    sc_restart = 0;
    case (sc_state)
      SC_OP: operator_byte(b);
      SC_LINE: begin
        if (b == 8'h0a) sc_state = SC_IDLE;
        else if (b == 0) start_token(b);
      end
      SC_BLOCK: begin
        if (b == "*") sc_state = SC_BSTAR;
        else if (b == 0) start_token(b);
      end
      SC_BSTAR: begin
        if (b == "/") sc_state = SC_IDLE;
        else if (b == 0) start_token(b);
        else if (b != "*") sc_state = SC_BLOCK;
      end
      SC_IDENT: begin
        if (c_alpha(b) || c_digit(b) || b == "_") begin
          if (sc_tlen < 9) sc_word[sc_tlen] = b;
          sc_tlen = sat_inc(sc_tlen);
        end else begin
          emit_tok(word_kind(), sc_tlen);
          start_token(b);
        end
      end
      SC_STR: begin
        if (b == sc_pend) begin
          emit_tok(sc_pend == "\"" ? K_DSTR : K_SSTR, sat_inc(sc_tlen));
          sc_state = SC_IDLE;
        end else if (b == 0) stop_on(E_UNTERM);
        else sc_tlen = sat_inc(sc_tlen);
      end
      SC_ZERO: begin
        if (b == "x" || b == "X") begin
          sc_flags = 4'b1000; sc_state = SC_HEX; sc_tlen = sat_inc(sc_tlen);
        end else if (b == "b" || b == "B") begin
          sc_flags = 4'b1100; sc_state = SC_BIN; sc_tlen = sat_inc(sc_tlen);
        end else if (b >= "0" && b <= "7") begin
          sc_flags = 4'b0100; sc_state = SC_DEC; sc_tlen = sat_inc(sc_tlen);
        end else begin
          sc_state = SC_DEC;
          decimal_byte(b);
        end
      end
      SC_DEC: decimal_byte(b);
      SC_HEX: begin
        if (c_xdigit(b)) sc_tlen = sat_inc(sc_tlen);
        else if (b == "." && !sc_flags[0]) begin
          sc_flags[0] = 1; sc_tlen = sat_inc(sc_tlen);
        end else if (b == "p" || b == "P") begin
          sc_flags[1] = 1; sc_state = SC_EXP0; sc_tlen = sat_inc(sc_tlen);
        end else close_number(b);
      end
      SC_BIN: begin
        if (b == "0" || b == "1") sc_tlen = sat_inc(sc_tlen);
        else close_number(b);
      end
      SC_EXP0: begin
        if (b == "+" || b == "-" || c_digit(b)) begin
          sc_state = SC_EXP; sc_tlen = sat_inc(sc_tlen);
        end else stop_on(E_BAD_EXP);
      end
      SC_EXP: begin
        if (c_digit(b)) sc_tlen = sat_inc(sc_tlen);
        else if (sc_flags[3:2] == 2'd2 ? (b == "p" || b == "P") : (b == "e" || b == "E"))
          stop_on(E_TWO_EXP);
        else close_number(b);
      end
      default: start_token(b);
    endcase
    if (sc_restart) begin
      sc_off = 0; sc_line = 1; sc_col = 1;
    end else begin
      if (~&sc_off) sc_off++;
      if (b == 8'h0a) begin
        if (~&sc_line) sc_line++;
        sc_col = 1;
      end else if (~&sc_col) sc_col++;
    end
    if (step_n > 0) step_recs[step_n-1].last = 1'b1;
    if (step_n == 2) n_twins++;
    for (int i = 0; i < step_n; i++) token_expect.push_back(step_recs[i]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tokens(in_char_in);
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_src.size() > 0 && byte_src[0] == DRAIN_MARK) begin
          // hold until every pending word is back
          in_valid <= 1'b0;
          if (token_expect.size() == 0) void'(byte_src.pop_front());
        end else if (byte_src.size() == 0 ||
                     (n_sent < 320 && $urandom_range(99) < 27) ||
                     (n_sent >= 320 && n_sent < 640 && $urandom_range(99) < 62)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_char_in <= 8'(byte_src.pop_front());
        end
      end
    end
  end

  // long output hold, counted down on its own
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_used && n_sent >= 800) begin
      hold_used <= 1'b1;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    rec_t want;
    rec_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind: out_token_kind, off: out_start_offset, len: out_token_length,
                line: out_begin_line, col: out_begin_column, err: out_error_code,
                last: out_last_result};
        if (token_expect.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected word: kind %0d off %0d", got.kind, got.off);
        end else begin
          want = token_expect.pop_front();
          n_tokens++;
          if (got != want) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch word %0d: exp k%0d o%0d l%0d ln%0d c%0d e%0d z%0d",
                       n_tokens, want.kind, want.off, want.len, want.line, want.col,
                       want.err, want.last);
              $display("  got k%0d o%0d l%0d ln%0d c%0d e%0d z%0d",
                       got.kind, got.off, got.len, got.line, got.col, got.err, got.last);
            end
          end
        end
      end
      if (hold_left > 0) out_stall <= 1'b1;
      else if (n_sent < 320) out_stall <= $urandom_range(99) < 62;
      else if (n_sent < 640) out_stall <= $urandom_range(99) < 27;
      else out_stall <= 1'b0;
    end
  end

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) byte_src.push_back(s[i]);
  endtask

  function automatic string digits(string set, int lo, int hi);
    string s = "";
    int n = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) s = {s, string'(set[$urandom_range(set.len() - 1)])};
    return s;
  endfunction

  function automatic string any_bytes(int n, logic [7:0] ban0, logic [7:0] ban1);
    string s = "";
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(255, 1)); while (b == ban0 || b == ban1);
      s = {s, string'(b)};
    end
    return s;
  endfunction

  // An empty result stands for the end-of-text byte, which a string cannot hold.
  function automatic string make_token();
    string ops [19] = '{"||", "|", "&&", "&", "!=", "!", "<=", "<", ">=", ">", "==",
                        "=", "->", "-", "/", "*", ".", "+", "%"};
    string sgn [3] = '{"", "+", "-"};
    string s;
    case ($urandom_range(11))
      0: s = kw_text[$urandom_range(29)];
      1, 2: s = {digits("abcxyzEFQ_", 1, 1),
                 digits("abcdefghijklmnopqrstuvwxyzABCXYZ0123456789_", 0, 12)};
      3: s = {digits("123456789", 1, 1), digits("0123456789", 0, 5)};
      4: s = {"0", digits("01234567", 1, 4), $urandom_range(1) ? "" : ".5"};
      5: s = {"0", digits("xX", 1, 1), digits("0123456789abcdefABCDEF", 1, 6),
              $urandom_range(1) ? "" : {".", digits("0123456789abcdef", 1, 3)},
              $urandom_range(1) ? "" : {digits("pP", 1, 1), sgn[$urandom_range(2)],
                                        digits("0123456789", 1, 3),
                                        $urandom_range(1) ? "" : "F"}};
      6: s = {"0", digits("bB", 1, 1), digits("01", 1, 10)};
      7: s = {digits("0123456789", 1, 4),
              $urandom_range(1) ? "" : {".", digits("0123456789", 0, 3)},
              digits("eE", 1, 1), sgn[$urandom_range(2)], digits("0123456789", 1, 3),
              $urandom_range(1) ? "" : "f"};
      8: s = $urandom_range(1) ? {"\"", any_bytes($urandom_range(6), "\"", "\""), "\""}
                               : {"'", any_bytes($urandom_range(6), "'", "'"), "'"};
      9: s = $urandom_range(1) ? {"//", any_bytes($urandom_range(8), 8'h0a, 8'h0a), "\n"}
                               : {"/*", any_bytes($urandom_range(8), "*", "/"), "**/"};
      10: s = "";
      default: s = $urandom_range(3) == 0 ? digits("()[]{},;:", 1, 1)
                                          : ops[$urandom_range(18)];
    endcase
    return s;
  endfunction

  initial begin
    string gaps [6] = '{" ", "\t", "\n", "\v", "\f", "\r"};
    string tail;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // hand-picked opening: operators, lookahead, every number base, keyword, end of text
    put_text("a|b->c!=0x1.8p-2F;017 0b1 1.5e+3f protected func_ 'x'\n");
    byte_src.push_back(0);
    put_text("x/*\xff*");
    byte_src.push_back(0);
    while (byte_src.size() < 950) begin
      if (byte_src.size() > 480 && byte_src.size() < 500) byte_src.push_back(DRAIN_MARK);
      tail = make_token();
      if (tail.len() == 0) byte_src.push_back(0);
      else put_text(tail);
      // glue punctuation straight on now and then, so one byte closes two tokens
      if ($urandom_range(3) == 0) put_text(digits("()[]{},;:+%", 1, 1));
      put_text(gaps[$urandom_range(5)]);
    end
    // finish with one error, then bytes the stopped block must ignore
    case ($urandom_range(4))
      0: put_text($urandom_range(1) ? "$" : "\x80");
      1: put_text("12e;");
      2: put_text("0x1p3p");
      3: put_text("42f");
      default: begin put_text("\"open"); byte_src.push_back(0); end
    endcase
    put_text("abc 1 +");
    while (byte_src.size() > 0 || in_valid || token_expect.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (token_expect.size() > 0) n_errors++;
    $display("%0d bytes in, %0d token words checked, %0d bytes gave two words",
             n_sent, n_tokens, n_twins);
    $display("covered stalls both ways, a long output hold, a drain pause, ending in an error");
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    sc_state = SC_IDLE; sc_pend = 0; sc_tstart = 0; sc_off = 0; sc_line = 1; sc_col = 1;
    sc_tline = 1; sc_tcol = 1; sc_tlen = 0; sc_flags = 0; sc_stopped = 0; sc_restart = 0;
    for (int i = 0; i < 9; i++) sc_word[i] = 0;
  end
endmodule
